// ===== design/xmr_pkg.sv =====
// Package of types, codes and constants shared by the XMODEM receiver files.
`default_nettype none

package xmr_pkg;

  // Default number of payload bytes in one frame.
  localparam int unsigned PAYLOAD_BYTES_DEF = 128;

  // Block number expected first after reset of the register.
  localparam logic [7:0] FIRST_BLOCK_RST = 8'h01;

  // Lead bytes of a frame.
  localparam logic [7:0] LEAD_SOH = 8'h01;
  localparam logic [7:0] LEAD_EOT = 8'h04;

  // Block number plus its complement must give this sum.
  localparam logic [8:0] BLOCK_PAIR_SUM = 9'd255;

  // Input operation codes.
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPLY   = 1'b1;

  // Reply codes to the sender.
  typedef enum logic [1:0] {
    RPL_ACK = 2'd0,
    RPL_NAK = 2'd1,
    RPL_CAN = 2'd2
  } reply_e;

  // One input item.
  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    reply_e     reply;
    logic       commit;
    logic       done_res;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/xmr_in_if.sv =====
// Handshake interface for the input channel of the XMODEM receiver.
`default_nettype none

interface xmr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/xmr_out_if.sv =====
// Handshake interface for the result channel of the XMODEM receiver.
`default_nettype none

interface xmr_out_if;
  logic            valid;
  logic            ready;
  logic            kind;
  logic [7:0]      data_byte;
  logic [6:0]      byte_index;
  xmr_pkg::reply_e reply;
  logic            commit;
  logic            done_res;

  modport source (
    output valid, output kind, output data_byte, output byte_index,
    output reply, output commit, output done_res, input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input byte_index,
    input reply, input commit, input done_res, output ready
  );
endinterface

`default_nettype wire

// ===== design/xmr_in_stage.sv =====
// Input register stage of the XMODEM receiver.
`default_nettype none

module xmr_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire xmr_pkg::in_item_t in_item_i,
  output logic                   in_ready_o,
  input  wire logic              advance_ok_i,
  output logic                   item_valid_o,
  output xmr_pkg::in_item_t      item_o
);

  logic              valid_q;
  xmr_pkg::in_item_t item_q;

  // The register takes a new item when empty or when its item moves on.
  assign in_ready_o = !valid_q || advance_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ===== design/xmr_core.sv =====
// Frame decoder and transfer state of the XMODEM receiver.
`default_nettype none

module xmr_core #(
  parameter int unsigned PAYLOAD_BYTES = xmr_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              item_valid_i,
  input  wire xmr_pkg::in_item_t item_i,
  input  wire logic              advance_i,
  input  wire logic [7:0]        first_block_i,
  output logic                   res_valid_o,
  output xmr_pkg::out_item_t     res_o
);

  localparam int unsigned FPOS_W = $clog2(PAYLOAD_BYTES + 4);
  localparam logic [FPOS_W-1:0] POS_LEAD  = FPOS_W'(0);
  localparam logic [FPOS_W-1:0] POS_BLOCK = FPOS_W'(1);
  localparam logic [FPOS_W-1:0] POS_COMPL = FPOS_W'(2);
  localparam logic [FPOS_W-1:0] POS_DATA  = FPOS_W'(3);
  localparam logic [FPOS_W-1:0] POS_CSUM  = FPOS_W'(PAYLOAD_BYTES + 3);

  logic              active_q, active_d;
  logic              eot_pending_q, eot_pending_d;
  logic [7:0]        expected_block_q, expected_block_d;
  logic [FPOS_W-1:0] frame_pos_q, frame_pos_d;
  logic [7:0]        block_byte_q, block_byte_d;
  logic [7:0]        complement_byte_q, complement_byte_d;
  logic [7:0]        running_sum_q, running_sum_d;

  logic              res_valid;
  logic              rpl_en;
  xmr_pkg::reply_e   rpl_code;
  logic              rpl_commit;
  logic              rpl_done;
  logic [FPOS_W-1:0] data_idx;
  logic [8:0]        pair_sum;

  assign data_idx = frame_pos_q - POS_DATA;
  assign pair_sum = {1'b0, block_byte_q} + {1'b0, complement_byte_q};

  // Next state and result for the item held in the input register.
  always_comb begin
    active_d          = active_q;
    eot_pending_d     = eot_pending_q;
    expected_block_d  = expected_block_q;
    frame_pos_d       = frame_pos_q;
    block_byte_d      = block_byte_q;
    complement_byte_d = complement_byte_q;
    running_sum_d     = running_sum_q;
    res_valid         = 1'b0;
    rpl_en            = 1'b0;
    rpl_code          = xmr_pkg::RPL_ACK;
    rpl_commit        = 1'b0;
    rpl_done          = 1'b0;
    res_o             = '0;
    res_o.reply       = xmr_pkg::RPL_ACK;

    if (item_i.opcode == xmr_pkg::OP_START) begin
      active_d          = 1'b1;
      eot_pending_d     = 1'b0;
      expected_block_d  = first_block_i;
      frame_pos_d       = POS_LEAD;
      block_byte_d      = 8'h00;
      complement_byte_d = 8'h00;
      running_sum_d     = 8'h00;
    end else if (active_q) begin
      if (frame_pos_q == POS_LEAD) begin
        // Lead byte: SOH opens a frame, EOT ends the transfer in two steps, others cancel.
        if (eot_pending_q) begin
          rpl_en   = 1'b1;
          rpl_done = 1'b1;
          rpl_code = (item_i.rx_byte == xmr_pkg::LEAD_EOT) ? xmr_pkg::RPL_ACK
                                                            : xmr_pkg::RPL_CAN;
        end else if (item_i.rx_byte == xmr_pkg::LEAD_SOH) begin
          frame_pos_d   = POS_BLOCK;
          running_sum_d = 8'h00;
        end else if (item_i.rx_byte == xmr_pkg::LEAD_EOT) begin
          eot_pending_d = 1'b1;
          rpl_en        = 1'b1;
          rpl_code      = xmr_pkg::RPL_NAK;
        end else begin
          rpl_en   = 1'b1;
          rpl_done = 1'b1;
          rpl_code = xmr_pkg::RPL_CAN;
        end
      end else if (frame_pos_q == POS_BLOCK) begin
        block_byte_d = item_i.rx_byte;
        frame_pos_d  = POS_COMPL;
      end else if (frame_pos_q == POS_COMPL) begin
        complement_byte_d = item_i.rx_byte;
        frame_pos_d       = POS_DATA;
      end else if (frame_pos_q < POS_CSUM) begin
        // Payload byte streams straight out and joins the checksum.
        running_sum_d    = running_sum_q + item_i.rx_byte;
        frame_pos_d      = frame_pos_q + FPOS_W'(1);
        res_valid        = 1'b1;
        res_o.kind       = xmr_pkg::KIND_PAYLOAD;
        res_o.data_byte  = item_i.rx_byte;
        res_o.byte_index = 7'(data_idx);
      end else begin
        // Checksum byte closes the frame and judges it.
        frame_pos_d = POS_LEAD;
        rpl_en      = 1'b1;
        if (block_byte_q != expected_block_q || pair_sum != xmr_pkg::BLOCK_PAIR_SUM) begin
          rpl_done = 1'b1;
          rpl_code = xmr_pkg::RPL_CAN;
        end else if (item_i.rx_byte != running_sum_q) begin
          running_sum_d = 8'h00;
          rpl_code      = xmr_pkg::RPL_NAK;
        end else begin
          running_sum_d    = 8'h00;
          expected_block_d = expected_block_q + 8'd1;
          rpl_code         = xmr_pkg::RPL_ACK;
          rpl_commit       = 1'b1;
        end
      end
    end

    // A reply item; one that ends the transfer also drops the state.
    if (rpl_en) begin
      res_valid      = 1'b1;
      res_o.kind     = xmr_pkg::KIND_REPLY;
      res_o.reply    = rpl_code;
      res_o.commit   = rpl_commit;
      res_o.done_res = rpl_done;
      if (rpl_done) begin
        active_d      = 1'b0;
        eot_pending_d = 1'b0;
        frame_pos_d   = POS_LEAD;
        running_sum_d = 8'h00;
      end
    end
  end

  assign res_valid_o = item_valid_i && res_valid;

  // Transfer state moves on only when the held item leaves the register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q          <= 1'b0;
      eot_pending_q     <= 1'b0;
      expected_block_q  <= 8'h00;
      frame_pos_q       <= POS_LEAD;
      block_byte_q      <= 8'h00;
      complement_byte_q <= 8'h00;
      running_sum_q     <= 8'h00;
    end else if (advance_i) begin
      active_q          <= active_d;
      eot_pending_q     <= eot_pending_d;
      expected_block_q  <= expected_block_d;
      frame_pos_q       <= frame_pos_d;
      block_byte_q      <= block_byte_d;
      complement_byte_q <= complement_byte_d;
      running_sum_q     <= running_sum_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/xmr_out_stage.sv =====
// Result register stage of the XMODEM receiver.
`default_nettype none

module xmr_out_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               res_valid_i,
  input  wire xmr_pkg::out_item_t res_i,
  output logic                    load_ok_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output xmr_pkg::out_item_t      out_item_o
);

  logic               valid_q;
  xmr_pkg::out_item_t item_q;

  // The register loads when empty or when its item is taken this cycle.
  assign load_ok_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ok_o) begin
      valid_q <= res_valid_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_ok_o && res_valid_i) begin
      item_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

// ===== design/xmodem_receiver.sv =====
// Top level of the byte-serial XMODEM checksum receiver.
//
//   Channel   Direction  Handshake           Payload
//   rx_i      in         valid/ready         opcode, rx_byte
//   tx_o      out        valid/ready         kind, data_byte, byte_index, reply,
//                                            commit, done_res
//   cfg       in         cfg_we_i (no wait)  cfg_wdata_i = first_block
//
// One item a cycle is accepted while the result register is not stalled. An item's result,
// if it has one, is formed by the frame decoder from the item in the input register and is
// presented from the result register.
// Reset clears the transfer state and sets first_block to 1; no clearing pass.
// A stalled result holds in the result register and holds the item behind it; the
// input register takes an item while it is empty or while the result register is
// empty or being emptied.
// A write to first_block takes effect at the next start item.
`default_nettype none

module xmodem_receiver #(
  parameter int unsigned PAYLOAD_BYTES = xmr_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  xmr_in_if.sink          rx_i,
  xmr_out_if.source       tx_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  logic               first_block_q;
  logic [7:0]         first_block_val_q;
  xmr_pkg::in_item_t  in_item;
  xmr_pkg::in_item_t  item;
  logic               item_valid;
  logic               load_ok;
  logic               advance;
  logic               res_valid;
  xmr_pkg::out_item_t res;
  xmr_pkg::out_item_t out_item;

  // Configuration register; the flag marks it as written since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_block_q     <= 1'b0;
      first_block_val_q <= xmr_pkg::FIRST_BLOCK_RST;
    end else if (cfg_we_i) begin
      first_block_q     <= 1'b1;
      first_block_val_q <= cfg_wdata_i;
    end
  end

  assign in_item.opcode  = rx_i.opcode;
  assign in_item.rx_byte = rx_i.rx_byte;

  // The held item moves on whenever the result register can take its result.
  assign advance = item_valid && load_ok;

  xmr_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (rx_i.valid),
    .in_item_i    (in_item),
    .in_ready_o   (rx_i.ready),
    .advance_ok_i (load_ok),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  xmr_core #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .advance_i     (advance),
    .first_block_i (first_block_q ? first_block_val_q : xmr_pkg::FIRST_BLOCK_RST),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  xmr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .load_ok_o   (load_ok),
    .out_valid_o (tx_o.valid),
    .out_ready_i (tx_o.ready),
    .out_item_o  (out_item)
  );

  assign tx_o.kind       = out_item.kind;
  assign tx_o.data_byte  = out_item.data_byte;
  assign tx_o.byte_index = out_item.byte_index;
  assign tx_o.reply      = out_item.reply;
  assign tx_o.commit     = out_item.commit;
  assign tx_o.done_res   = out_item.done_res;

endmodule

`default_nettype wire
